### design/pfw_pkg.sv
// shared types, character codes and helpers for the paragraph fill block
`timescale 1ns / 1ps

package pfw_pkg;

    // default word buffer depth
    localparam int WORD_CAP_DEF = 48;

    // field widths
    localparam int CHAR_W = 8;
    localparam int COL_W  = 10;
    localparam int LINE_W = 11;

    // line length ceiling
    localparam logic [LINE_W-1:0] LINE_MAX = 11'd2047;

    // register reset values
    localparam logic [COL_W-1:0] FILL_RESET  = 10'd72;
    localparam logic [COL_W-1:0] START_RESET = 10'd0;

    // register indexes
    localparam logic REG_FILL  = 1'b0;
    localparam logic REG_START = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_EXCL   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_WORD,
        ST_NL
    } t_state;

    // what goes out ahead of a word
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_SPACE,
        PRE_BREAK
    } t_pre;

    // load request into the output register
    typedef struct packed {
        logic              load;
        logic [CHAR_W-1:0] char_val;
        logic              last;
    } t_out_req;

    // separator test
    function automatic logic f_is_sep(input logic [CHAR_W-1:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
    endfunction

    // word ends a sentence: terminal punctuation after lower case or closer,
    // and not opening with a capital
    function automatic logic f_ends_sentence(
        input logic              two_or_more,
        input logic [CHAR_W-1:0] first_ch,
        input logic [CHAR_W-1:0] prev_ch,
        input logic [CHAR_W-1:0] last_ch
    );
        logic term_ok;
        logic prev_ok;
        logic first_ok;
        term_ok  = (last_ch == CH_EXCL) || (last_ch == CH_QUEST) || (last_ch == CH_DOT);
        prev_ok  = ((prev_ch >= CH_LC_A) && (prev_ch <= CH_LC_Z)) ||
                   (prev_ch == CH_DQUOTE) || (prev_ch == CH_SQUOTE) ||
                   (prev_ch == CH_RPAREN) || (prev_ch == CH_RBRACK);
        first_ok = (first_ch < CH_UC_A) || (first_ch > CH_UC_Z);
        return two_or_more && term_ok && prev_ok && first_ok;
    endfunction

endpackage

### design/pfw_word_buf.sv
// word buffer memory: one write port, one registered read port
`timescale 1ns / 1ps

module pfw_word_buf #(
    parameter int WORD_CAP = pfw_pkg::WORD_CAP_DEF,
    parameter int AW       = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [pfw_pkg::CHAR_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [pfw_pkg::CHAR_W-1:0] o_rdata
);

    logic [pfw_pkg::CHAR_W-1:0] r_mem [WORD_CAP];
    logic [pfw_pkg::CHAR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pfw_out_reg.sv
// output register between the sequencer and the master stream
`timescale 1ns / 1ps

module pfw_out_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfw_pkg::t_out_req          i_req,
    output logic                       o_slot_free,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [pfw_pkg::CHAR_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);

    logic                       r_valid;
    logic [pfw_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;

    assign o_slot_free = !r_valid || m_axis_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_req.load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_slot_free && i_req.load) begin
            r_char <= i_req.char_val;
            r_last <= i_req.last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_char;
    assign m_axis_tlast  = r_last;

endmodule

### design/pfw_fill_ctrl.sv
// fill sequencer: gathers words, decides placement, replays words from the buffer
`timescale 1ns / 1ps

module pfw_fill_ctrl #(
    parameter int WORD_CAP = pfw_pkg::WORD_CAP_DEF,
    parameter int AW       = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1,
    parameter int CW       = $clog2(WORD_CAP + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pfw_pkg::COL_W-1:0]  i_fill_col,
    input  logic [pfw_pkg::COL_W-1:0]  i_start_col,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [pfw_pkg::CHAR_W-1:0] i_in_char,
    input  logic                       i_in_end,
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic                       o_mem_re,
    output logic [AW-1:0]              o_mem_raddr,
    input  logic [pfw_pkg::CHAR_W-1:0] i_mem_rdata,
    input  logic                       i_slot_free,
    output pfw_pkg::t_out_req          o_req
);

    localparam int SUM_W = pfw_pkg::LINE_W + 1;
    localparam logic [CW-1:0] CAP = CW'(WORD_CAP);

    pfw_pkg::t_state r_state, n_state;
    pfw_pkg::t_pre   r_pre;

    logic [CW-1:0]                 r_count;
    logic [pfw_pkg::LINE_W-1:0]    r_ll;
    logic                          r_fp;
    logic                          r_se;
    logic                          r_ps;
    logic                          r_end;
    logic [AW-1:0]                 r_idx;
    logic [pfw_pkg::CHAR_W-1:0]    r_first;
    logic [pfw_pkg::CHAR_W-1:0]    r_prev;
    logic [pfw_pkg::CHAR_W-1:0]    r_last;

    logic                          acc;
    logic                          is_sep;
    logic                          do_flush;
    logic                          do_store;
    logic                          word_held;
    logic [pfw_pkg::LINE_W-1:0]    base_ll;
    logic [SUM_W-1:0]              trial;
    logic                          fits;
    logic [SUM_W-1:0]              ll_plus1;
    logic [pfw_pkg::LINE_W-1:0]    ll_space;
    logic [SUM_W-1:0]              ll_grow;
    logic [pfw_pkg::LINE_W-1:0]    ll_grown;
    logic                          last_char;
    logic [CW-1:0]                 idx_next;

    // input decode
    assign acc       = i_in_valid && o_in_ready;
    assign is_sep    = pfw_pkg::f_is_sep(i_in_char);
    assign word_held = (r_count != '0);
    assign do_flush  = acc && (i_in_end || is_sep);
    assign do_store  = acc && !i_in_end && !is_sep && (r_count < CAP);

    // line length at this item, start column on the first item of a paragraph
    assign base_ll = r_ps ? pfw_pkg::LINE_W'(i_start_col) : r_ll;

    // fit test on the unsaturated sum
    assign trial = SUM_W'(base_ll) + SUM_W'(1) + SUM_W'(r_se) + SUM_W'(r_count);
    assign fits  = (trial <= SUM_W'(i_fill_col)) || (base_ll == '0);

    // saturating growth for a leading space and for the word itself
    assign ll_plus1 = SUM_W'(base_ll) + SUM_W'(1);
    assign ll_space = (ll_plus1 > SUM_W'(pfw_pkg::LINE_MAX)) ? pfw_pkg::LINE_MAX
                                                             : ll_plus1[pfw_pkg::LINE_W-1:0];
    assign ll_grow  = SUM_W'(r_ll) + SUM_W'(r_count);
    assign ll_grown = (ll_grow > SUM_W'(pfw_pkg::LINE_MAX)) ? pfw_pkg::LINE_MAX
                                                            : ll_grow[pfw_pkg::LINE_W-1:0];

    // word replay position
    assign idx_next  = CW'(r_idx) + CW'(1);
    assign last_char = (idx_next == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfw_pkg::ST_IDLE: begin
                if (do_flush) begin
                    if (word_held) begin
                        n_state = pfw_pkg::ST_PRE;
                    end else if (i_in_end) begin
                        n_state = pfw_pkg::ST_NL;
                    end
                end
            end
            pfw_pkg::ST_PRE: begin
                if (r_pre == pfw_pkg::PRE_NONE || i_slot_free) begin
                    n_state = pfw_pkg::ST_WORD;
                end
            end
            pfw_pkg::ST_WORD: begin
                if (i_slot_free && last_char) begin
                    n_state = r_end ? pfw_pkg::ST_NL : pfw_pkg::ST_IDLE;
                end
            end
            pfw_pkg::ST_NL: begin
                if (i_slot_free) begin
                    n_state = pfw_pkg::ST_IDLE;
                end
            end
            default: n_state = pfw_pkg::ST_IDLE;
        endcase
    end

    // outputs: handshake, memory ports, output load
    always_comb begin
        o_in_ready     = 1'b0;
        o_mem_we       = do_store;
        o_mem_waddr    = r_count[AW-1:0];
        o_mem_re       = 1'b0;
        o_mem_raddr    = '0;
        o_req.load     = 1'b0;
        o_req.char_val = pfw_pkg::CH_NL;
        o_req.last     = 1'b0;
        case (r_state)
            pfw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                // fetch the first character ahead of the replay
                o_mem_re   = do_flush && word_held;
            end
            pfw_pkg::ST_PRE: begin
                o_req.load     = (r_pre != pfw_pkg::PRE_NONE) && i_slot_free;
                o_req.char_val = (r_pre == pfw_pkg::PRE_SPACE) ? pfw_pkg::CH_SPACE
                                                               : pfw_pkg::CH_NL;
            end
            pfw_pkg::ST_WORD: begin
                o_req.load     = i_slot_free;
                o_req.char_val = i_mem_rdata;
                o_req.last     = last_char && !r_end;
                o_mem_re       = i_slot_free && !last_char;
                o_mem_raddr    = idx_next[AW-1:0];
            end
            pfw_pkg::ST_NL: begin
                o_req.load = i_slot_free;
                o_req.last = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfw_pkg::ST_IDLE;
            r_pre   <= pfw_pkg::PRE_NONE;
            r_count <= '0;
            r_ll    <= '0;
            r_fp    <= 1'b1;
            r_se    <= 1'b0;
            r_ps    <= 1'b1;
            r_end   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_ps  <= 1'b0;
                r_end <= i_in_end;
                if (do_store) begin
                    r_count <= r_count + CW'(1);
                end
                // placement decision when a held word is flushed
                if (do_flush && word_held) begin
                    r_idx <= '0;
                    r_fp  <= 1'b0;
                    r_se  <= pfw_pkg::f_ends_sentence(r_count >= CW'(2), r_first, r_prev,
                                                      r_last);
                    if (fits) begin
                        r_pre <= r_fp ? pfw_pkg::PRE_NONE : pfw_pkg::PRE_SPACE;
                        r_ll  <= r_fp ? base_ll : ll_space;
                    end else begin
                        r_pre <= pfw_pkg::PRE_BREAK;
                        r_ll  <= '0;
                    end
                end else begin
                    r_ll <= base_ll;
                end
            end
            // word replay
            if (r_state == pfw_pkg::ST_WORD && i_slot_free) begin
                if (last_char) begin
                    r_ll    <= ll_grown;
                    r_count <= '0;
                end else begin
                    r_idx <= idx_next[AW-1:0];
                end
            end
            // paragraph end rearms
            if (r_state == pfw_pkg::ST_NL && i_slot_free) begin
                r_ll    <= '0;
                r_fp    <= 1'b1;
                r_se    <= 1'b0;
                r_ps    <= 1'b1;
                r_count <= '0;
            end
        end
    end

    // first, second to last and last stored characters for the sentence test
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_last <= i_in_char;
            r_prev <= r_last;
            if (!word_held) begin
                r_first <= i_in_char;
            end
        end
    end

endmodule

### design/paragraph_fill_word_wrap_unit.sv
// top level of the greedy paragraph fill block
`timescale 1ns / 1ps

//  channel  | direction | payload                          | handshake
//  s_axis   | in        | tdata: in_char[7:0]; tlast: para_end | tvalid/tready
//  m_axis   | out       | tdata: out_char[7:0]; tlast: out_last | tvalid/tready
//  cfg      | in        | i_cfg_idx 0 fill_column, 1 start_column | i_cfg_we
//
// A word character is written to the word buffer while it has room.
// A separator that ends a held word is accepted, then passes a slot for
// a leading space or break (spent even when none goes out), then one buffer read
// per character; the final item adds the line break.
// Reset is synchronous and active low; the buffer needs no clearing pass.
// A stalled master side holds the replay; the input waits until it is done.

module paragraph_fill_word_wrap_unit #(
    parameter int WORD_CAP = pfw_pkg::WORD_CAP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [pfw_pkg::COL_W-1:0]  i_cfg_data,
    // input characters
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [pfw_pkg::CHAR_W-1:0] s_axis_tdata,   // [7:0] in_char
    input  logic                       s_axis_tlast,
    // output characters
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [pfw_pkg::CHAR_W-1:0] m_axis_tdata,   // [7:0] out_char
    output logic                       m_axis_tlast
);

    localparam int AW = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
    localparam int CW = $clog2(WORD_CAP + 1);

    logic [pfw_pkg::COL_W-1:0]  r_fill_col;
    logic [pfw_pkg::COL_W-1:0]  r_start_col;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [pfw_pkg::CHAR_W-1:0] mem_rdata;
    logic                       slot_free;
    pfw_pkg::t_out_req          out_req;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_col  <= pfw_pkg::FILL_RESET;
            r_start_col <= pfw_pkg::START_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfw_pkg::REG_FILL:  r_fill_col  <= i_cfg_data;
                pfw_pkg::REG_START: r_start_col <= i_cfg_data;
                default:            r_fill_col  <= r_fill_col;
            endcase
        end
    end

    pfw_word_buf #(
        .WORD_CAP (WORD_CAP),
        .AW       (AW)
    ) u_word_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pfw_fill_ctrl #(
        .WORD_CAP (WORD_CAP),
        .AW       (AW),
        .CW       (CW)
    ) u_fill_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fill_col  (r_fill_col),
        .i_start_col (r_start_col),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_char   (s_axis_tdata),
        .i_in_end    (s_axis_tlast),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .i_slot_free (slot_free),
        .o_req       (out_req)
    );

    pfw_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (out_req),
        .o_slot_free   (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### dv/tb_top.sv
// self-checking testbench for the paragraph fill block
`timescale 1ns / 1ps

module tb_top;

    localparam int WORD_CAP    = pfw_pkg::WORD_CAP_DEF;
    localparam int CHAR_W      = pfw_pkg::CHAR_W;
    localparam int COL_W       = pfw_pkg::COL_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 8;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_item;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // block ports, all inputs known from time zero
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_idx     = pfw_pkg::REG_FILL;
    logic [COL_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata  = '0;   // [7:0] in_char
    logic              s_axis_tlast  = 1'b0;  // para_end
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CHAR_W-1:0] m_axis_tdata;          // [7:0] out_char
    logic              m_axis_tlast;          // out_last

    paragraph_fill_word_wrap_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_char_item pending_in_chars[$];
    t_char_item expected_out_chars[$];
    int         mismatches   = 0;
    int         cycle_count  = 0;
    int         items_queued = 0;
    int         gap_pct      = 10;
    int         stall_pct    = 10;

    // fill state mirror
    logic [CHAR_W-1:0] held_word[$];
    int                held_len;
    int                line_len;
    bit                first_word_due;
    bit                sentence_done;
    bit                para_fresh;
    logic [COL_W-1:0]  fill_col;
    logic [COL_W-1:0]  start_col;

    task automatic note_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic void grow_line(input int amount);
        line_len = (line_len + amount > int'(pfw_pkg::LINE_MAX)) ? int'(pfw_pkg::LINE_MAX)
                                                                 : line_len + amount;
    endfunction

    // terminal punctuation after lower case or a closer, first char not a capital
    function automatic bit held_word_closes_sentence();
        logic [CHAR_W-1:0] lst, prv, fst;
        bit                term_ok, prev_ok;
        if (held_len < 2)
            return 1'b0;
        lst = held_word[held_len-1];
        prv = held_word[held_len-2];
        fst = held_word[0];
        term_ok = (lst == pfw_pkg::CH_EXCL) || (lst == pfw_pkg::CH_QUEST) ||
                  (lst == pfw_pkg::CH_DOT);
        prev_ok = (prv >= pfw_pkg::CH_LC_A && prv <= pfw_pkg::CH_LC_Z) ||
                  (prv == pfw_pkg::CH_DQUOTE) || (prv == pfw_pkg::CH_SQUOTE) ||
                  (prv == pfw_pkg::CH_RPAREN) || (prv == pfw_pkg::CH_RBRACK);
        return term_ok && prev_ok && (fst < pfw_pkg::CH_UC_A || fst > pfw_pkg::CH_UC_Z);
    endfunction

    // place the held word on the line, breaking first when it does not fit
    task automatic place_word(ref t_char_item outs[$]);
        int trial;
        if (held_len == 0)
            return;
        trial = line_len + 1 + (sentence_done ? 1 : 0) + held_len;
        if (trial <= int'(fill_col) || line_len == 0) begin
            if (!first_word_due) begin
                outs.push_back('{pfw_pkg::CH_SPACE, 1'b0});
                grow_line(1);
            end
        end else begin
            outs.push_back('{pfw_pkg::CH_NL, 1'b0});
            line_len = 0;
        end
        first_word_due = 1'b0;
        for (int i = 0; i < held_len; i++)
            outs.push_back('{held_word[i], 1'b0});
        grow_line(held_len);
        sentence_done = held_word_closes_sentence();
        held_len = 0;
        held_word.delete();
    endtask

    // work out the characters one accepted input item produces
    task automatic fill_one_char(input logic [CHAR_W-1:0] ch, input logic fin);
        t_char_item outs[$];
        if (para_fresh) begin
            line_len   = int'(start_col);
            para_fresh = 1'b0;
        end
        if (fin) begin
            place_word(outs);
            outs.push_back('{pfw_pkg::CH_NL, 1'b0});
            held_len       = 0;
            held_word.delete();
            line_len       = 0;
            first_word_due = 1'b1;
            sentence_done  = 1'b0;
            para_fresh     = 1'b1;
        end else if (ch == pfw_pkg::CH_SPACE || ch == pfw_pkg::CH_TAB ||
                     ch == pfw_pkg::CH_NL) begin
            place_word(outs);
        end else if (held_len < WORD_CAP) begin
            held_word.push_back(ch);
            held_len++;
        end
        if (outs.size() > 0)
            outs[outs.size()-1].last = 1'b1;
        foreach (outs[i])
            expected_out_chars.push_back(outs[i]);
    endtask

    // input driver with random idle bursts
    int         gap_left = 0;
    t_char_item next_in;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                fill_one_char(s_axis_tdata, s_axis_tlast);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left == 0 && gap_pct != 0 && pending_in_chars.size() != 0 &&
                    $urandom_range(1, 100) <= gap_pct)
                    gap_left = $urandom_range(1, 18);
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_in_chars.size() != 0) begin
                    next_in = pending_in_chars.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_in.ch;
                    s_axis_tlast  <= next_in.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0 && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            stall_left = $urandom_range(1, 18);
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // output monitor
    t_char_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_out_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected char %02h", m_axis_tdata));
            end else begin
                want = expected_out_chars.pop_front();
                if (m_axis_tdata !== want.ch)
                    note_mismatch($sformatf("out_char %02h, wanted %02h", m_axis_tdata, want.ch));
                if (m_axis_tlast !== want.last)
                    note_mismatch($sformatf("out_last %0b, wanted %0b", m_axis_tlast, want.last));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic fin);
        pending_in_chars.push_back('{ch, fin});
        items_queued++;
    endtask

    // wait until every item is taken and every result has come, then settle
    task automatic drain_block();
        do @(negedge i_clk);
        while (pending_in_chars.size() != 0 || s_axis_tvalid || expected_out_chars.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic set_columns(input logic [COL_W-1:0] fill, input logic [COL_W-1:0] start);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pfw_pkg::REG_FILL;
        i_cfg_data <= fill;
        fill_col    = fill;
        @(posedge i_clk);
        i_cfg_idx  <= pfw_pkg::REG_START;
        i_cfg_data <= start;
        start_col   = start;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_sep();
        case ($urandom_range(0, 2))
            0:       return pfw_pkg::CH_SPACE;
            1:       return pfw_pkg::CH_TAB;
            default: return pfw_pkg::CH_NL;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_punct();
        case ($urandom_range(0, 6))
            0:       return pfw_pkg::CH_EXCL;
            1:       return pfw_pkg::CH_QUEST;
            2:       return pfw_pkg::CH_DOT;
            3:       return pfw_pkg::CH_DQUOTE;
            4:       return pfw_pkg::CH_SQUOTE;
            5:       return pfw_pkg::CH_RPAREN;
            default: return pfw_pkg::CH_RBRACK;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_word_char();
        int                r;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 55)
            return pfw_pkg::CH_LC_A + CHAR_W'($urandom_range(0, 25));
        if (r < 70)
            return pfw_pkg::CH_UC_A + CHAR_W'($urandom_range(0, 25));
        if (r < 85)
            return pick_punct();
        do c = CHAR_W'($urandom_range(0, 255));
        while (c == pfw_pkg::CH_SPACE || c == pfw_pkg::CH_TAB || c == pfw_pkg::CH_NL);
        return c;
    endfunction

    // one word, often shaped to close a sentence
    task automatic queue_word(input int len);
        logic [CHAR_W-1:0] w[$];
        for (int i = 0; i < len; i++)
            w.push_back(pick_word_char());
        if (len >= 2 && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0:       w[len-1] = pfw_pkg::CH_EXCL;
                1:       w[len-1] = pfw_pkg::CH_QUEST;
                default: w[len-1] = pfw_pkg::CH_DOT;
            endcase
            if ($urandom_range(0, 4) == 0)
                w[len-2] = pick_punct();
            else
                w[len-2] = pfw_pkg::CH_LC_A + CHAR_W'($urandom_range(0, 25));
        end
        foreach (w[i])
            queue_char(w[i], 1'b0);
    endtask

    // mostly words and separators, some noise and early paragraph ends
    task automatic queue_random_text(input int n);
        int stop, r, len;
        stop = items_queued + n;
        while (items_queued < stop) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                queue_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
            end else if (r < 9) begin
                queue_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 88)
                    len = $urandom_range(1, 9);
                else if (r < 95)
                    len = $urandom_range(10, 40);
                else
                    len = $urandom_range(45, 62);
                queue_word(len);
                queue_char(pick_sep(), 1'b0);
                if ($urandom_range(0, 6) == 0)
                    queue_char(pick_sep(), 1'b0);
            end
        end
        queue_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    logic [COL_W-1:0] fill_pick, start_pick;

    initial begin
        held_len       = 0;
        line_len       = 0;
        first_word_due = 1'b1;
        sentence_done  = 1'b0;
        para_fresh     = 1'b1;
        fill_col       = pfw_pkg::FILL_RESET;
        start_col      = pfw_pkg::START_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: sentence end, empty separator, tab, extreme bytes, capital start
        queue_char("a", 1'b0);
        queue_char("b", 1'b0);
        queue_char(pfw_pkg::CH_DOT, 1'b0);
        queue_char(pfw_pkg::CH_SPACE, 1'b0);
        queue_char(pfw_pkg::CH_SPACE, 1'b0);
        queue_char(pfw_pkg::CH_DQUOTE, 1'b0);
        queue_char("Q", 1'b0);
        queue_char(pfw_pkg::CH_TAB, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(pfw_pkg::CH_NL, 1'b0);
        queue_char("Z", 1'b0);
        queue_char("z", 1'b0);
        queue_char(pfw_pkg::CH_QUEST, 1'b0);
        queue_char(pfw_pkg::CH_SPACE, 1'b0);
        queue_char(pfw_pkg::CH_RBRACK, 1'b0);
        queue_char(pfw_pkg::CH_EXCL, 1'b0);
        queue_char(pfw_pkg::CH_SPACE, 1'b0);
        // paragraph end ignores its char; then an empty paragraph end
        queue_char("k", 1'b0);
        queue_char(pfw_pkg::CH_SPACE, 1'b1);
        queue_char(8'hFF, 1'b1);
        drain_block();

        // narrowest fill with widest start: every word breaks
        set_columns(10'd1, 10'd1023);
        queue_char("a", 1'b0);
        queue_char(pfw_pkg::CH_SPACE, 1'b0);
        queue_char("b", 1'b0);
        queue_char("c", 1'b0);
        queue_char(pfw_pkg::CH_NL, 1'b1);
        drain_block();

        // random phases over a spread of column settings
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin fill_pick = 10'd1023; start_pick = 10'd0;    end
                1: begin fill_pick = 10'd0;    start_pick = 10'd5;    end
                2: begin fill_pick = 10'd12;   start_pick = 10'd1023; end
                3: begin fill_pick = 10'd1;    start_pick = 10'd3;    end
                4: begin fill_pick = 10'd25;   start_pick = 10'd0;    end
                5: begin
                    fill_pick  = COL_W'($urandom_range(1, 1023));
                    start_pick = COL_W'($urandom_range(0, 1023));
                end
                6: begin fill_pick = 10'd30;   start_pick = 10'd7;    end
                default: begin fill_pick = 10'd72; start_pick = 10'd1; end
            endcase
            case (p)
                3, 7:    begin gap_pct = 0;  stall_pct = 0;  end
                5:       begin gap_pct = 35; stall_pct = 35; end
                default: begin gap_pct = 10; stall_pct = 10; end
            endcase
            set_columns(fill_pick, start_pick);
            queue_random_text(37);
            drain_block();
        end

        repeat (30) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
